/* hw/rtl/rtc_tse_pkg.sv */
// Package with shared types, codes and field-update functions for the time-set editor.
package rtc_tse_pkg;

    // Key codes carried with every input item.
    localparam logic [2:0] KEY_NONE = 3'd0;
    localparam logic [2:0] KEY_NEXT = 3'd1;
    localparam logic [2:0] KEY_UP   = 3'd2;
    localparam logic [2:0] KEY_DOWN = 3'd3;
    localparam logic [2:0] KEY_SAVE = 3'd4;

    // Setting modes; the restore step after the second field is never stored.
    localparam logic [2:0] MODE_SHOW    = 3'd0;
    localparam logic [2:0] MODE_YEAR    = 3'd1;
    localparam logic [2:0] MODE_MONTH   = 3'd2;
    localparam logic [2:0] MODE_DATE    = 3'd3;
    localparam logic [2:0] MODE_WEEKDAY = 3'd4;
    localparam logic [2:0] MODE_HOUR    = 3'd5;
    localparam logic [2:0] MODE_MINUTE  = 3'd6;
    localparam logic [2:0] MODE_SECOND  = 3'd7;

    // Field limits.
    localparam logic [6:0] YEAR_MAX    = 7'd99;
    localparam logic [6:0] MONTH_MAX   = 7'd12;
    localparam logic [6:0] WEEKDAY_MAX = 7'd7;
    localparam logic [6:0] HOUR_MAX    = 7'd23;
    localparam logic [6:0] MINUTE_MAX  = 7'd59;
    localparam logic [6:0] SECOND_MAX  = 7'd59;
    localparam logic [6:0] DATE_LEAP   = 7'd29;
    localparam logic [6:0] DATE_FEB    = 7'd28;
    localparam logic [6:0] DATE_SHORT  = 7'd30;
    localparam logic [6:0] DATE_LONG   = 7'd31;

    // Stream widths.
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] date;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [2:0] weekday;
    } time_t;

    typedef struct packed {
        logic [2:0] key_code;
        time_t      clock;
    } in_item_t;

    typedef struct packed {
        logic [2:0] edit_mode;
        time_t      set_time;
        logic       write_clock;
    } result_t;

    localparam time_t TIME_RESET = '{
        year: 7'd0, month: 4'd1, date: 5'd1, hour: 5'd0,
        minute: 6'd0, second: 6'd0, weekday: 3'd1
    };

    // Field that wraps over 0..hi; anything above hi after the key becomes 0.
    function automatic logic [6:0] wrap_zero(logic [6:0] v, logic [2:0] key, logic [6:0] hi);
        logic [7:0] t;
        t = {1'b0, v};
        if (key == KEY_UP) begin
            t = {1'b0, v} + 8'd1;
        end else if (key == KEY_DOWN) begin
            t = (v == 7'd0) ? {1'b0, hi} : ({1'b0, v} - 8'd1);
        end
        if (t > {1'b0, hi}) begin
            t = 8'd0;
        end
        return t[6:0];
    endfunction

    // Field that wraps over 1..hi; above hi becomes 1, below 1 becomes hi.
    function automatic logic [6:0] wrap_one(logic [6:0] v, logic [2:0] key, logic [6:0] hi);
        logic [7:0] t;
        t = {1'b0, v};
        if (key == KEY_UP) begin
            t = {1'b0, v} + 8'd1;
        end else if (key == KEY_DOWN) begin
            t = (v <= 7'd1) ? 8'd0 : ({1'b0, v} - 8'd1);
        end
        if (t > {1'b0, hi}) begin
            t = 8'd1;
        end else if (t == 8'd0) begin
            t = {1'b0, hi};
        end
        return t[6:0];
    endfunction

    // Last day of the month; a leap year is any year divisible by four.
    function automatic logic [6:0] date_limit(logic [6:0] year, logic [3:0] month);
        logic [6:0] lim;
        lim = DATE_LONG;
        if (month == 4'd2) begin
            lim = (year[1:0] == 2'd0) ? DATE_LEAP : DATE_FEB;
        end else if (month == 4'd4 || month == 4'd6 || month == 4'd9 || month == 4'd11) begin
            lim = DATE_SHORT;
        end
        return lim;
    endfunction

endpackage

/* hw/rtl/rtc_tse_in_reg.sv */
// Input register stage: one slave transfer per cycle unless it is full and held.
module rtc_tse_in_reg (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rtc_tse_pkg::in_item_t in_item,
    output logic                  item_valid,
    input  logic                  item_take,
    output rtc_tse_pkg::in_item_t item
);

    logic                  valid_reg;
    logic                  valid_next;
    rtc_tse_pkg::in_item_t item_reg;

    // The stage can load whenever it is empty or its item moves on this cycle.
    assign in_ready = !valid_reg || item_take;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload is captured on every accepted transfer.
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* hw/rtl/rtc_tse_step.sv */
// Editor state (mode, edit buffer, backup) and the one-pass update logic.
module rtc_tse_step (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_en,
    input  rtc_tse_pkg::in_item_t item,
    output rtc_tse_pkg::result_t  result
);

    logic [2:0]          mode_reg;
    logic [2:0]          mode_next;
    rtc_tse_pkg::time_t  edit_reg;
    rtc_tse_pkg::time_t  edit_next;
    rtc_tse_pkg::time_t  saved_reg;
    logic [2:0]          mode_adv;
    logic                restore;
    logic                take_backup;
    logic                wr;
    logic [6:0]          new_year;
    logic [6:0]          new_month;
    logic [6:0]          new_date;
    logic [6:0]          new_weekday;
    logic [6:0]          new_hour;
    logic [6:0]          new_minute;
    logic [6:0]          new_second;

    // Key NEXT advances the mode first; past the second field comes the restore step.
    assign restore     = (item.key_code == rtc_tse_pkg::KEY_NEXT) &&
                         (mode_reg == rtc_tse_pkg::MODE_SECOND);
    assign take_backup = (item.key_code == rtc_tse_pkg::KEY_NEXT) &&
                         (mode_reg == rtc_tse_pkg::MODE_SHOW);
    assign mode_adv    = (item.key_code == rtc_tse_pkg::KEY_NEXT) ? (mode_reg + 3'd1) : mode_reg;

    // Candidate value of every field, each under its own wrap rule.
    assign new_year    = rtc_tse_pkg::wrap_zero(edit_reg.year, item.key_code,
                                                rtc_tse_pkg::YEAR_MAX);
    assign new_month   = rtc_tse_pkg::wrap_one({3'd0, edit_reg.month}, item.key_code,
                                               rtc_tse_pkg::MONTH_MAX);
    assign new_date    = rtc_tse_pkg::wrap_one({2'd0, edit_reg.date}, item.key_code,
                             rtc_tse_pkg::date_limit(edit_reg.year, edit_reg.month));
    assign new_weekday = rtc_tse_pkg::wrap_one({4'd0, edit_reg.weekday}, item.key_code,
                                               rtc_tse_pkg::WEEKDAY_MAX);
    assign new_hour    = rtc_tse_pkg::wrap_zero({2'd0, edit_reg.hour}, item.key_code,
                                                rtc_tse_pkg::HOUR_MAX);
    assign new_minute  = rtc_tse_pkg::wrap_zero({1'b0, edit_reg.minute}, item.key_code,
                                                rtc_tse_pkg::MINUTE_MAX);
    assign new_second  = rtc_tse_pkg::wrap_zero({1'b0, edit_reg.second}, item.key_code,
                                                rtc_tse_pkg::SECOND_MAX);

    // Restore, or apply the action of the new mode; then a save key ends editing.
    always_comb begin
        edit_next = edit_reg;
        mode_next = mode_adv;
        wr        = 1'b0;
        if (restore) begin
            edit_next = saved_reg;
            mode_next = rtc_tse_pkg::MODE_SHOW;
            wr        = 1'b1;
        end else begin
            case (mode_adv)
                rtc_tse_pkg::MODE_SHOW:    edit_next = item.clock;
                rtc_tse_pkg::MODE_YEAR:    edit_next.year    = new_year;
                rtc_tse_pkg::MODE_MONTH:   edit_next.month   = new_month[3:0];
                rtc_tse_pkg::MODE_DATE:    edit_next.date    = new_date[4:0];
                rtc_tse_pkg::MODE_WEEKDAY: edit_next.weekday = new_weekday[2:0];
                rtc_tse_pkg::MODE_HOUR:    edit_next.hour    = new_hour[4:0];
                rtc_tse_pkg::MODE_MINUTE:  edit_next.minute  = new_minute[5:0];
                rtc_tse_pkg::MODE_SECOND:  edit_next.second  = new_second[5:0];
                default:                   edit_next = edit_reg;
            endcase
            if (mode_adv != rtc_tse_pkg::MODE_SHOW && item.key_code == rtc_tse_pkg::KEY_SAVE) begin
                mode_next = rtc_tse_pkg::MODE_SHOW;
                wr        = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= rtc_tse_pkg::MODE_SHOW;
            edit_reg <= rtc_tse_pkg::TIME_RESET;
        end else if (step_en) begin
            mode_reg <= mode_next;
            edit_reg <= edit_next;
        end
    end

    // Backup of the buffer as it stood when editing began.
    always_ff @(posedge aclk) begin
        if (step_en && take_backup) begin
            saved_reg <= edit_reg;
        end
    end

    assign result.edit_mode   = mode_next;
    assign result.set_time    = edit_next;
    assign result.write_clock = wr;

`ifndef SYNTHESIS
    // A write to the clock always leaves the editor showing time.
    a_write_ends_edit: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && wr) |-> (mode_next == rtc_tse_pkg::MODE_SHOW))
        else $error("write_clock raised while still editing");

    // Entering year edit from show mode stores the mode for the next item.
    a_enter_year: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && take_backup) |=> (mode_reg == rtc_tse_pkg::MODE_YEAR))
        else $error("mode did not advance to year edit");

    // The restore step reloads the backup taken on entry.
    a_restore_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && restore) |=> (edit_reg == $past(saved_reg)))
        else $error("restore did not reload the backup");

    // Month edit always leaves a legal month.
    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && !restore && mode_adv == rtc_tse_pkg::MODE_MONTH) |->
        (edit_next.month >= 4'd1 && edit_next.month <= 4'd12))
        else $error("month left out of range");
`endif

endmodule

/* hw/rtl/rtc_tse_out_reg.sv */
// Result register stage that drives the master channel.
module rtc_tse_out_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 res_valid,
    output logic                 res_ready,
    input  rtc_tse_pkg::result_t res,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rtc_tse_pkg::result_t out_res
);

    logic                 valid_reg;
    logic                 valid_next;
    rtc_tse_pkg::result_t res_reg;

    // The register can load when it is empty or its content leaves this cycle.
    assign res_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (res_ready) begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

/* hw/rtl/rtc_time_set_editor.sv */
// Top level of the clock time-set editor with stream input and result channels.
//
// Usage: every slave transfer is one pass of the time-setting control loop. It carries
// a key code and the time currently read from the clock chip. Every transfer yields
// exactly one master transfer with the setting mode, the seven-field edit buffer and
// a write flag that asks for the buffer to be written to the clock chip.
// Path: an accepted input transfer loads the input register, after which its result loads
// the result register that drives m_tvalid and m_tdata. Throughput is one item per cycle
// unless m_tready stalls the result register; the loop through the mode and edit-buffer
// registers sets it.
// Reset: aresetn low for one clock empties both stages and returns the editor to
// show mode with the buffer at year 0, January 1st, weekday 1, 00:00:00.
// Stalls: while m_tready is low the result register holds its transfer; the input
// register still takes one more item, and s_tready drops only when both are full.
// The backup restored at the end of an editing round is taken on entry to year edit.
module rtc_time_set_editor (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // key_code[2:0], clock_year[9:3], clock_month[13:10], clock_date[18:14],
    // clock_hour[23:19], clock_minute[29:24], clock_second[35:30],
    // clock_weekday[38:36], zero pad [39]
    input  logic [rtc_tse_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // edit_mode[2:0], set_year[9:3], set_month[13:10], set_date[18:14],
    // set_hour[23:19], set_minute[29:24], set_second[35:30],
    // set_weekday[38:36], write_clock[39]
    output logic [rtc_tse_pkg::OUT_DATA_W-1:0] m_tdata
);

    rtc_tse_pkg::in_item_t in_item;
    rtc_tse_pkg::in_item_t item;
    rtc_tse_pkg::result_t  res;
    rtc_tse_pkg::result_t  out_res;
    logic                  item_valid;
    logic                  res_ready;
    logic                  step_en;

    // Unpack the slave transfer.
    assign in_item.key_code      = s_tdata[2:0];
    assign in_item.clock.year    = s_tdata[9:3];
    assign in_item.clock.month   = s_tdata[13:10];
    assign in_item.clock.date    = s_tdata[18:14];
    assign in_item.clock.hour    = s_tdata[23:19];
    assign in_item.clock.minute  = s_tdata[29:24];
    assign in_item.clock.second  = s_tdata[35:30];
    assign in_item.clock.weekday = s_tdata[38:36];

    rtc_tse_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (res_ready),
        .item       (item)
    );

    // The state advances exactly when an item moves into the result register.
    assign step_en = item_valid && res_ready;

    rtc_tse_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (item),
        .result  (res)
    );

    rtc_tse_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (item_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Pack the master transfer.
    assign m_tdata = {out_res.write_clock,
                      out_res.set_time.weekday,
                      out_res.set_time.second,
                      out_res.set_time.minute,
                      out_res.set_time.hour,
                      out_res.set_time.date,
                      out_res.set_time.month,
                      out_res.set_time.year,
                      out_res.edit_mode};

endmodule

/* test/tb.sv */
// Self-checking bench, clock time-set editor: directed key walk, random sessions, key noise.
module tb;

    // One past the second field comes the restore step, which is never shown.
    localparam int NUM_MODES    = 9;
    localparam int WATCHDOG_MAX = 1000;
    localparam int SETTLE_WAIT  = 10;

    logic                               aclk     = 1'b0;
    logic                               aresetn  = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [rtc_tse_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [rtc_tse_pkg::OUT_DATA_W-1:0] m_tdata;

    // Editor state as predicted from the accepted key items.
    int                   ed_mode;
    rtc_tse_pkg::time_t   ed_buf;
    rtc_tse_pkg::time_t   ed_backup;
    rtc_tse_pkg::result_t expected_results[$];

    int error_count   = 0;
    int result_count  = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int quiet_cycles  = 0;

    rtc_time_set_editor DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic rtc_tse_pkg::time_t make_time(int y, int mo, int d, int h, int mi,
                                                     int s, int w);
        rtc_tse_pkg::time_t t;
        t.year    = y[6:0];
        t.month   = mo[3:0];
        t.date    = d[4:0];
        t.hour    = h[4:0];
        t.minute  = mi[5:0];
        t.second  = s[5:0];
        t.weekday = w[2:0];
        return t;
    endfunction

    // Either a plausible clock reading or arbitrary bits in every field.
    function automatic rtc_tse_pkg::time_t random_clock(bit in_range);
        if (in_range) begin
            return make_time($urandom_range(99), $urandom_range(12, 1), $urandom_range(31, 1),
                             $urandom_range(23), $urandom_range(59), $urandom_range(59),
                             $urandom_range(7, 1));
        end
        return make_time($urandom_range(127), $urandom_range(15), $urandom_range(31),
                         $urandom_range(31), $urandom_range(63), $urandom_range(63),
                         $urandom_range(7));
    endfunction

    // Up/down over 0..hi; anything above hi afterwards falls back to 0.
    function automatic int wrap_from_zero(int v, logic [2:0] key, int hi);
        int n;
        n = v;
        if (key == rtc_tse_pkg::KEY_UP) begin
            n = n + 1;
        end else if (key == rtc_tse_pkg::KEY_DOWN) begin
            n = (n == 0) ? hi : n - 1;
        end
        if (n > hi) begin
            n = 0;
        end
        return n;
    endfunction

    // Up/down over 1..hi; above hi gives 1, below 1 gives hi.
    function automatic int wrap_from_one(int v, logic [2:0] key, int hi);
        int n;
        n = v;
        if (key == rtc_tse_pkg::KEY_UP) begin
            n = n + 1;
        end else if (key == rtc_tse_pkg::KEY_DOWN) begin
            n = n - 1;
        end
        if (n > hi) begin
            n = 1;
        end
        if (n < 1) begin
            n = hi;
        end
        return n;
    endfunction

    function automatic int month_days(int year, int month);
        if (month == 2) begin
            return (year % 4 == 0) ? int'(rtc_tse_pkg::DATE_LEAP) : int'(rtc_tse_pkg::DATE_FEB);
        end
        if (month == 4 || month == 6 || month == 9 || month == 11) begin
            return int'(rtc_tse_pkg::DATE_SHORT);
        end
        return int'(rtc_tse_pkg::DATE_LONG);
    endfunction

    // One pass of the control loop: updates the predicted state, returns the expected result.
    function automatic rtc_tse_pkg::result_t editor_step(logic [2:0] key,
                                                         rtc_tse_pkg::time_t clk);
        rtc_tse_pkg::result_t r;
        int                   v;
        r.write_clock = 1'b0;
        if (key == rtc_tse_pkg::KEY_NEXT) begin
            ed_mode = (ed_mode + 1) % NUM_MODES;
            if (ed_mode == rtc_tse_pkg::MODE_YEAR) begin
                ed_backup = ed_buf;
            end
        end
        case (ed_mode)
            rtc_tse_pkg::MODE_SHOW: begin
                ed_buf = clk;
            end
            rtc_tse_pkg::MODE_YEAR: begin
                v = wrap_from_zero(ed_buf.year, key, rtc_tse_pkg::YEAR_MAX);
                ed_buf.year = v[6:0];
            end
            rtc_tse_pkg::MODE_MONTH: begin
                v = wrap_from_one(ed_buf.month, key, rtc_tse_pkg::MONTH_MAX);
                ed_buf.month = v[3:0];
            end
            rtc_tse_pkg::MODE_DATE: begin
                v = wrap_from_one(ed_buf.date, key, month_days(ed_buf.year, ed_buf.month));
                ed_buf.date = v[4:0];
            end
            rtc_tse_pkg::MODE_WEEKDAY: begin
                v = wrap_from_one(ed_buf.weekday, key, rtc_tse_pkg::WEEKDAY_MAX);
                ed_buf.weekday = v[2:0];
            end
            rtc_tse_pkg::MODE_HOUR: begin
                v = wrap_from_zero(ed_buf.hour, key, rtc_tse_pkg::HOUR_MAX);
                ed_buf.hour = v[4:0];
            end
            rtc_tse_pkg::MODE_MINUTE: begin
                v = wrap_from_zero(ed_buf.minute, key, rtc_tse_pkg::MINUTE_MAX);
                ed_buf.minute = v[5:0];
            end
            rtc_tse_pkg::MODE_SECOND: begin
                v = wrap_from_zero(ed_buf.second, key, rtc_tse_pkg::SECOND_MAX);
                ed_buf.second = v[5:0];
            end
            default: begin
                ed_buf = ed_backup;
                r.write_clock = 1'b1;
                ed_mode = rtc_tse_pkg::MODE_SHOW;
            end
        endcase
        // Save from any field mode writes the buffer and leaves editing.
        if (ed_mode >= rtc_tse_pkg::MODE_YEAR && ed_mode <= rtc_tse_pkg::MODE_SECOND &&
            key == rtc_tse_pkg::KEY_SAVE) begin
            r.write_clock = 1'b1;
            ed_mode = rtc_tse_pkg::MODE_SHOW;
        end
        r.edit_mode = ed_mode[2:0];
        r.set_time  = ed_buf;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at result %0d: %s", result_count, msg);
        error_count++;
    endtask

    task automatic compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            report_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
        end
    endtask

    task automatic check_result(logic [rtc_tse_pkg::OUT_DATA_W-1:0] d);
        rtc_tse_pkg::result_t want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result 0x%h with nothing expected", d));
        end else begin
            want = expected_results.pop_front();
            compare_field("edit_mode", want.edit_mode, d[2:0]);
            compare_field("set_year", want.set_time.year, d[9:3]);
            compare_field("set_month", want.set_time.month, d[13:10]);
            compare_field("set_date", want.set_time.date, d[18:14]);
            compare_field("set_hour", want.set_time.hour, d[23:19]);
            compare_field("set_minute", want.set_time.minute, d[29:24]);
            compare_field("set_second", want.set_time.second, d[35:30]);
            compare_field("set_weekday", want.set_time.weekday, d[38:36]);
            compare_field("write_clock", want.write_clock, d[39]);
        end
        result_count++;
    endtask

    // Result side: random stalls and a check of every transfer.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            check_result(m_tdata);
        end
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog on cycles in which neither channel completes a transfer.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("[rtc_time_set_editor] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Sends one key item with the clock reading and records its expected result.
    task automatic send_item(logic [2:0] key, rtc_tse_pkg::time_t clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, clk.weekday, clk.second, clk.minute, clk.hour, clk.date,
                     clk.month, clk.year, key};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        expected_results.push_back(editor_step(key, clk));
    endtask

    // Holds the sender off until every expected result has arrived.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // A key that tends to walk through a whole editing round.
    function automatic logic [2:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (ed_mode == rtc_tse_pkg::MODE_SHOW) begin
            if (r < 25) return rtc_tse_pkg::KEY_NEXT;
            if (r < 35) return rtc_tse_pkg::KEY_SAVE;
            if (r < 45) return rtc_tse_pkg::KEY_UP;
            if (r < 55) return rtc_tse_pkg::KEY_DOWN;
            if (r < 65) return 3'($urandom_range(7, 5));
            return rtc_tse_pkg::KEY_NONE;
        end
        if (r < 32) return rtc_tse_pkg::KEY_UP;
        if (r < 64) return rtc_tse_pkg::KEY_DOWN;
        if (r < 80) return rtc_tse_pkg::KEY_NEXT;
        if (r < 85) return rtc_tse_pkg::KEY_SAVE;
        if (r < 92) return rtc_tse_pkg::KEY_NONE;
        return 3'($urandom_range(7, 5));
    endfunction

    // Field extremes, wrap both ways from year to weekday, leap February, restore, save.
    task automatic test_directed_walk();
        rtc_tse_pkg::time_t max_clk;
        max_clk = make_time(99, 12, 31, 23, 59, 59, 7);
        send_item(rtc_tse_pkg::KEY_NONE, make_time(0, 0, 0, 0, 0, 0, 0));
        send_item(3'd5, make_time(127, 15, 31, 31, 63, 63, 7));
        send_item(3'd6, max_clk);
        send_item(rtc_tse_pkg::KEY_SAVE, max_clk);
        send_item(rtc_tse_pkg::KEY_NEXT, random_clock(1'b0));
        send_item(rtc_tse_pkg::KEY_UP, random_clock(1'b0));
        send_item(rtc_tse_pkg::KEY_DOWN, random_clock(1'b1));
        send_item(rtc_tse_pkg::KEY_UP, random_clock(1'b1));
        send_item(rtc_tse_pkg::KEY_NEXT, random_clock(1'b0));
        send_item(rtc_tse_pkg::KEY_UP, random_clock(1'b1));
        send_item(rtc_tse_pkg::KEY_DOWN, random_clock(1'b1));
        send_item(rtc_tse_pkg::KEY_UP, random_clock(1'b0));
        send_item(rtc_tse_pkg::KEY_UP, random_clock(1'b1));
        // February of a leap year: 31 is out of range and falls back to 1.
        send_item(rtc_tse_pkg::KEY_NEXT, random_clock(1'b1));
        send_item(rtc_tse_pkg::KEY_DOWN, random_clock(1'b0));
        send_item(rtc_tse_pkg::KEY_UP, random_clock(1'b1));
        send_item(rtc_tse_pkg::KEY_NEXT, random_clock(1'b1));
        send_item(rtc_tse_pkg::KEY_UP, random_clock(1'b0));
        send_item(rtc_tse_pkg::KEY_DOWN, random_clock(1'b1));
        send_item(rtc_tse_pkg::KEY_NEXT, random_clock(1'b1));
        send_item(rtc_tse_pkg::KEY_UP, random_clock(1'b0));
        send_item(rtc_tse_pkg::KEY_NEXT, random_clock(1'b1));
        send_item(rtc_tse_pkg::KEY_UP, random_clock(1'b1));
        send_item(rtc_tse_pkg::KEY_NEXT, random_clock(1'b0));
        send_item(rtc_tse_pkg::KEY_DOWN, random_clock(1'b1));
        send_item(rtc_tse_pkg::KEY_NEXT, random_clock(1'b1));
        send_item(rtc_tse_pkg::KEY_NEXT, random_clock(1'b0));
        send_item(rtc_tse_pkg::KEY_SAVE, random_clock(1'b1));
    endtask

    // Mostly well-formed editing rounds with random clock readings.
    task automatic test_random_editing(int count);
        for (int i = 0; i < count; i++) begin
            send_item(pick_key(), random_clock($urandom_range(1)));
        end
    endtask

    // Arbitrary key codes and clock bits.
    task automatic test_key_noise(int count);
        for (int i = 0; i < count; i++) begin
            send_item(3'($urandom_range(7)), random_clock(1'b0));
        end
    endtask

    initial begin
        int idle_table[4];
        int stall_table[4];
        idle_table  = '{0, 56, 0, 22};
        stall_table = '{0, 0, 56, 22};
        ed_mode   = rtc_tse_pkg::MODE_SHOW;
        ed_buf    = rtc_tse_pkg::TIME_RESET;
        ed_backup = rtc_tse_pkg::TIME_RESET;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_walk();
        drain_results();
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_table[p];
            stall_pct     = stall_table[p];
            test_random_editing(380);
            drain_results();
        end
        test_key_noise(180);
        drain_results();

        repeat (SETTLE_WAIT) @(posedge aclk);
        if (error_count == 0) begin
            $display("[rtc_time_set_editor] OK");
        end else begin
            $display("[rtc_time_set_editor] ERROR");
        end
        $finish;
    end

endmodule

/* rtc_time_set_editor.f */
hw/rtl/rtc_tse_pkg.sv
hw/rtl/rtc_tse_in_reg.sv
hw/rtl/rtc_tse_step.sv
hw/rtl/rtc_tse_out_reg.sv
hw/rtl/rtc_time_set_editor.sv
test/tb.sv
